// ===== hw/rtl/brqt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package brqt_pkg;
  localparam int DEPTH_DEF = 1024;
  localparam int BLOCK_DEF = 32;
  localparam int LEN_W     = 11;
  localparam int IDX_W     = 10;
  localparam int DATA_W    = 64;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_BAD   = 2'd3;

  localparam logic [1:0] OP_SUM = 2'd0;
  localparam logic [1:0] OP_MIN = 2'd1;
  localparam logic [1:0] OP_MAX = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_REFUSE = 2'd2;

  localparam logic REG_OP_SELECT = 1'b0;
  localparam logic REG_LENGTH    = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic       clr_step;   // write zero at clear address
    logic       load;       // capture input item
    logic       acc_clear;  // reset accumulator and sum scratch
    logic       elem_rd;    // issue element read at walk pointer
    logic       elem_fold;  // fold returned element into accumulator
    logic       elem_add;   // write back element plus delta
    logic       elem_set;   // write single element
    logic       bsum_acc;   // accumulate into scratch for block sum
    logic       bsum_store; // store rebuilt block sum
    logic       bsum_incr;  // add scratch onto the stored block sum
    logic       pend_add;   // add delta to pending of walk block
    logic       blk_fold;   // fold full block sum into accumulator
    logic       first;      // element fold is the first one
  } brqt_cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/blocked_range_query_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake           | Payload
// in       | in_valid/in_stall   | mode, index_low, index_high, value
// out      | out_valid/out_stall | result, status
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
// One item at a time: a query walks its range element by element, except that
// in sum mode full middle blocks are folded in whole from the block tables.
// An add also stores the sum of each edge block. A write rebuilds its whole block.
// A bad item goes straight to its answer. The element memory read port sets the
// pace, one element a cycle, paused while a block sum is stored. After reset a
// clearing pass zeroes the memory; in_stall is high.
// The result is held until out_stall is low; no new item is taken meanwhile.
module blocked_range_query_table #(
  parameter int DEPTH = brqt_pkg::DEPTH_DEF,
  parameter int BLOCK = brqt_pkg::BLOCK_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   mode,
  input  wire logic [brqt_pkg::IDX_W-1:0]   index_low,
  input  wire logic [brqt_pkg::IDX_W-1:0]   index_high,
  input  wire logic [brqt_pkg::DATA_W-1:0]  value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [brqt_pkg::DATA_W-1:0]       result,
  output logic [1:0]                        status,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [brqt_pkg::LEN_W-1:0]   cfg_data
);
  localparam int AW = $clog2(DEPTH);

  brqt_pkg::brqt_cmd_t             cmd;
  logic [AW-1:0]                   ptr;
  logic [AW-1:0]                   ptr_rd;
  logic [AW-1:0]                   clr_addr;
  logic [1:0]                      op_sel;
  logic [brqt_pkg::LEN_W-1:0]      len;
  logic [brqt_pkg::DATA_W-1:0]     acc;
  logic                            is_query;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op_sel <= brqt_pkg::OP_SUM;
      len    <= brqt_pkg::LEN_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == brqt_pkg::REG_OP_SELECT) begin
        if (cfg_data[1:0] <= brqt_pkg::OP_MAX) op_sel <= cfg_data[1:0];
      end else begin
        len <= cfg_data;
      end
    end
  end

  brqt_ctrl #(.DEPTH(DEPTH), .BLOCK(BLOCK)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .index_low(index_low), .index_high(index_high), .op_sel(op_sel), .len(len),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .is_query(is_query), .cmd(cmd), .ptr(ptr), .ptr_rd(ptr_rd), .clr_addr(clr_addr)
  );

  brqt_datapath #(.DEPTH(DEPTH), .BLOCK(BLOCK)) u_dp (
    .clk(clk), .cmd(cmd), .ptr(ptr), .ptr_rd(ptr_rd), .clr_addr(clr_addr),
    .op_sel(op_sel), .value(value), .acc(acc)
  );

  assign result = (is_query && status == brqt_pkg::ST_OK) ? acc : '0;
endmodule
`default_nettype wire

// ===== hw/rtl/brqt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brqt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/brqt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brqt_datapath #(
  parameter int DEPTH = brqt_pkg::DEPTH_DEF,
  parameter int BLOCK = brqt_pkg::BLOCK_DEF
) (
  input  wire logic                         clk,
  input  wire brqt_pkg::brqt_cmd_t          cmd,
  input  wire logic [$clog2(DEPTH)-1:0]     ptr,
  input  wire logic [$clog2(DEPTH)-1:0]     ptr_rd,
  input  wire logic [$clog2(DEPTH)-1:0]     clr_addr,
  input  wire logic [1:0]                   op_sel,
  input  wire logic [brqt_pkg::DATA_W-1:0]  value,
  output logic      [brqt_pkg::DATA_W-1:0]  acc
);
  localparam int AW    = $clog2(DEPTH);
  localparam int NBLK  = (DEPTH + BLOCK - 1) / BLOCK;
  localparam int BW    = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int DW    = brqt_pkg::DATA_W;
  localparam int SHB   = $clog2(BLOCK);

  logic [DW-1:0] val_q;
  logic [DW-1:0] pend [NBLK];
  logic [DW-1:0] bsum [NBLK];
  logic [DW-1:0] scratch;
  logic [DW-1:0] rdata;
  logic [DW-1:0] el_val;
  logic [DW-1:0] blk_val;
  logic [DW-1:0] wdata;
  logic [AW-1:0] waddr;
  logic          we;
  logic [BW-1:0] blk_w;
  logic [BW-1:0] blk_r;
  logic [BW-1:0] blk_c;

  // block of an index: divide by block size
  function automatic logic [BW-1:0] blk_of(input logic [AW-1:0] a);
    logic [AW-1:0] q;
    q = a / AW'(BLOCK);
    blk_of = BW'(q);
  endfunction

  assign blk_w = blk_of(ptr);
  assign blk_r = blk_of(ptr_rd);
  assign blk_c = blk_of(clr_addr);

  brqt_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ptr), .rdata(rdata)
  );

  // element write mux
  always_comb begin
    we    = cmd.clr_step | cmd.elem_add | cmd.elem_set;
    waddr = cmd.clr_step ? clr_addr : ptr_rd;
    wdata = '0;
    if (cmd.elem_add)      wdata = rdata + val_q;
    else if (cmd.elem_set) wdata = val_q - pend[blk_r];
  end

  assign el_val  = rdata + pend[blk_r];
  assign blk_val = bsum[blk_w] + (pend[blk_w] << SHB);

  // capture delta, accumulate and keep block tables
  always_ff @(posedge clk) begin
    if (cmd.load) val_q <= value;
    if (cmd.clr_step && (clr_addr % AW'(BLOCK)) == '0) begin
      bsum[blk_c] <= '0;
      pend[blk_c] <= '0;
    end
    if (cmd.acc_clear) begin
      acc     <= '0;
      scratch <= '0;
    end else begin
      // adds collect their deltas, writes collect the whole block
      if (cmd.bsum_acc) begin
        scratch <= scratch + (cmd.elem_add ? val_q : (cmd.elem_set ? wdata : rdata));
      end
      if (cmd.bsum_store) begin
        bsum[blk_r] <= cmd.bsum_incr ? bsum[blk_r] + scratch : scratch;
        scratch     <= '0;
      end
      if (cmd.pend_add) pend[blk_w] <= pend[blk_w] + val_q;
      if (cmd.elem_fold) begin
        if (cmd.first) acc <= el_val;
        else if (op_sel == brqt_pkg::OP_MIN) begin
          if ($signed(el_val) < $signed(acc)) acc <= el_val;
        end else if (op_sel == brqt_pkg::OP_MAX) begin
          if ($signed(acc) < $signed(el_val)) acc <= el_val;
        end else acc <= acc + el_val + (cmd.blk_fold ? blk_val : '0);
      end else if (cmd.blk_fold) begin
        acc <= acc + blk_val;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/brqt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brqt_ctrl #(
  parameter int DEPTH = brqt_pkg::DEPTH_DEF,
  parameter int BLOCK = brqt_pkg::BLOCK_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   mode,
  input  wire logic [brqt_pkg::IDX_W-1:0]   index_low,
  input  wire logic [brqt_pkg::IDX_W-1:0]   index_high,
  input  wire logic [1:0]                   op_sel,
  input  wire logic [brqt_pkg::LEN_W-1:0]   len,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        status,
  output logic                              is_query,
  output brqt_pkg::brqt_cmd_t               cmd,
  output logic [$clog2(DEPTH)-1:0]          ptr,
  output logic [$clog2(DEPTH)-1:0]          ptr_rd,
  output logic [$clog2(DEPTH)-1:0]          clr_addr
);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int IW = brqt_pkg::IDX_W;
  localparam int WW = (PW > IW) ? PW : IW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state;
  logic [1:0]    mode_q;
  logic [WW-1:0] lo_q;
  logic [WW-1:0] hi_q;
  logic [WW-1:0] cur;
  logic [WW-1:0] cur_rd;
  logic          rd_pend;
  logic          first_q;
  logic [WW-1:0] ncap;
  logic [WW-1:0] lo_w;
  logic [WW-1:0] hi_w;
  logic [WW-1:0] blk_lo;
  logic          bad;
  logic [WW-1:0] blo;
  logic [WW-1:0] bhi;
  logic [WW-1:0] bcur;
  logic          full_blk;
  logic          blk_end;
  logic          closing;

  assign ncap = (WW'(len) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(len);
  assign lo_w = WW'(index_low);
  assign hi_w = WW'(index_high);
  assign blk_lo = (lo_w / WW'(BLOCK)) * WW'(BLOCK);
  assign in_stall = (state != S_IDLE) || out_valid;
  assign ptr      = AW'(cur);
  assign ptr_rd   = AW'(cur_rd);
  assign is_query = (mode_q == brqt_pkg::MODE_QUERY);

  always_comb begin
    if (mode == brqt_pkg::MODE_WRITE) bad = (lo_w >= ncap);
    else bad = (mode == brqt_pkg::MODE_BAD) || (lo_w > hi_w) || (hi_w >= ncap);
  end

  assign blo  = lo_q / WW'(BLOCK);
  assign bhi  = hi_q / WW'(BLOCK);
  assign bcur = cur / WW'(BLOCK);
  // full middle block at a block start, handled through block tables
  assign full_blk = (mode_q != brqt_pkg::MODE_WRITE) && (op_sel == brqt_pkg::OP_SUM) &&
                    (bcur != blo) && (bcur != bhi) && ((cur % WW'(BLOCK)) == '0);
  // rebuild boundaries: returned read closes its block or the range
  assign blk_end  = ((cur_rd % WW'(BLOCK)) == WW'(BLOCK - 1)) ||
                    (cur_rd == WW'(DEPTH - 1)) || (cur_rd == hi_q);
  assign closing  = rd_pend && !is_query && blk_end;

  // command decode
  always_comb begin
    cmd = '0;
    cmd.first = first_q;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.load      = in_valid && !in_stall;
        cmd.acc_clear = in_valid && !in_stall;
      end
      S_WALK, S_DRAIN: begin
        if (state == S_WALK && !closing) begin
          if (full_blk) begin
            cmd.pend_add = (mode_q == brqt_pkg::MODE_ADD);
            cmd.blk_fold = (mode_q == brqt_pkg::MODE_QUERY);
          end else begin
            cmd.elem_rd = 1'b1;
          end
        end
        if (rd_pend) begin
          case (mode_q)
            brqt_pkg::MODE_QUERY: cmd.elem_fold = 1'b1;
            brqt_pkg::MODE_ADD: begin
              cmd.elem_add = 1'b1;
              cmd.bsum_acc = 1'b1;
            end
            default: begin
              cmd.bsum_acc = 1'b1;
              cmd.elem_set = (cur_rd == lo_q);
            end
          endcase
        end
      end
      S_STORE: begin
        cmd.bsum_store = 1'b1;
        cmd.bsum_incr  = (mode_q == brqt_pkg::MODE_ADD);
      end
      default: ;
    endcase
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            mode_q  <= mode;
            lo_q    <= lo_w;
            // write rebuilds its whole block
            hi_q    <= (mode == brqt_pkg::MODE_WRITE) ? blk_lo + WW'(BLOCK - 1) : hi_w;
            first_q <= (op_sel != brqt_pkg::OP_SUM);
            rd_pend <= 1'b0;
            if (bad) begin
              status <= brqt_pkg::ST_RANGE;
              state  <= S_DONE;
            end else if (mode == brqt_pkg::MODE_ADD && op_sel != brqt_pkg::OP_SUM) begin
              status <= brqt_pkg::ST_REFUSE;
              state  <= S_DONE;
            end else begin
              status <= brqt_pkg::ST_OK;
              cur    <= (mode == brqt_pkg::MODE_WRITE) ? blk_lo : lo_w;
              state  <= S_WALK;
            end
          end
        end
        S_WALK, S_DRAIN: begin
          if (rd_pend && is_query) first_q <= 1'b0;
          if (closing) begin
            // hold the walk while the closed block sum is stored
            rd_pend <= 1'b0;
            state   <= S_STORE;
          end else if (state == S_WALK && !full_blk) begin
            rd_pend <= 1'b1;
            cur_rd  <= cur;
            cur     <= cur + 1'b1;
            if (cur >= hi_q || cur == WW'(DEPTH - 1)) state <= S_DRAIN;
          end else begin
            rd_pend <= 1'b0;
            if (state == S_WALK) cur <= cur + WW'(BLOCK);
            else state <= S_DONE;
          end
        end
        S_STORE: begin
          if (cur > hi_q || cur >= WW'(DEPTH)) state <= S_DONE;
          else state <= S_WALK;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/brqt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brqt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] mode,
  input wire logic [1:0] status,
  input wire logic [63:0] result
);
  // no new item while a result waits
  a_one: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("item taken while result pending");
  // accepted item produces no result in the following cycle
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
  // non-ok result carries zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != brqt_pkg::ST_OK) |-> result == 64'd0)
    else $error("nonzero on error");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(result))
    else $error("result dropped");
  // refusal only for range add
  a_ref: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == brqt_pkg::MODE_WRITE) |=>
    !out_valid || status != brqt_pkg::ST_REFUSE)
    else $error("bad refusal");
endmodule

bind blocked_range_query_table brqt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .mode(mode),
  .status(status), .result(result)
);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import brqt_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         op_mode;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic [DATA_W-1:0]  val;
    logic               typed;
    logic [DATA_W-1:0]  exp_res;
    logic [1:0]         exp_st;
  } stim_row_t;

  typedef struct {
    logic [DATA_W-1:0] res;
    logic [1:0]        st;
  } answer_t;

  localparam logic [DATA_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam int HOLD_LEN = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_WRITE;
  logic [IDX_W-1:0] index_low = '0;
  logic [IDX_W-1:0] index_high = '0;
  logic [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] result;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_OP_SELECT;
  logic [LEN_W-1:0] cfg_data = '0;

  // model of the table: true element values plus register copies
  logic [DATA_W-1:0] true_elem [DEPTH_DEF];
  logic [1:0]        cur_op;
  logic [LEN_W-1:0]  cur_len;

  answer_t   answers_due[$];
  stim_row_t dir_tab[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int hold_req = 0;
  bit quiet = 1'b0;

  blocked_range_query_table i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .index_low(index_low), .index_high(index_high), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // work out one item's answer and apply it to the table copy
  function automatic answer_t fold_table(logic [1:0] m, logic [IDX_W-1:0] lo,
                                         logic [IDX_W-1:0] hi, logic [DATA_W-1:0] v);
    answer_t a;
    int n;
    a.res = '0;
    a.st = ST_OK;
    n = (cur_len > DEPTH_DEF) ? DEPTH_DEF : int'(cur_len);
    if (m == MODE_WRITE) begin
      if (lo >= n) a.st = ST_RANGE;
      else true_elem[lo] = v;
    end else if (!(m == MODE_ADD || m == MODE_QUERY) || lo > hi || hi >= n) begin
      a.st = ST_RANGE;
    end else if (m == MODE_ADD) begin
      if (cur_op != OP_SUM) a.st = ST_REFUSE;
      else for (int i = lo; i <= hi; i++) true_elem[i] += v;
    end else begin
      a.res = (cur_op == OP_SUM) ? '0 : true_elem[lo];
      for (int i = lo; i <= hi; i++) begin
        if (cur_op == OP_SUM) a.res += true_elem[i];
        else if (cur_op == OP_MIN && $signed(true_elem[i]) < $signed(a.res))
          a.res = true_elem[i];
        else if (cur_op == OP_MAX && $signed(true_elem[i]) > $signed(a.res))
          a.res = true_elem[i];
      end
    end
    return a;
  endfunction

  // offer one item and hold it until the transfer
  task automatic send_item(stim_row_t r);
    answer_t a;
    in_valid <= 1'b1;
    mode <= r.op_mode;
    index_low <= r.lo;
    index_high <= r.hi;
    value <= r.val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    a = fold_table(r.op_mode, r.lo, r.hi, r.val);
    if (r.typed) begin
      a.res = r.exp_res;
      a.st = r.exp_st;
    end
    answers_due.push_back(a);
    sent++;
  endtask

  task automatic sender_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!quiet) begin
      if (r < 3) n = $urandom_range(20, 60);
      else if (r < 30) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drain every outstanding answer before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [LEN_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OP_SELECT) begin
      if (data[1:0] <= OP_MAX) cur_op = data[1:0];
    end else begin
      cur_len = data;
    end
  endtask

  function automatic stim_row_t item(logic [1:0] m, int lo, int hi, logic [DATA_W-1:0] v);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.op_mode = m;
    r.lo = IDX_W'(lo);
    r.hi = IDX_W'(hi);
    r.val = v;
    r.typed = 1'b0;
    r.exp_res = '0;
    r.exp_st = ST_OK;
    return r;
  endfunction

  function automatic stim_row_t typed(logic [1:0] m, int lo, int hi, logic [DATA_W-1:0] v,
                                      logic [DATA_W-1:0] res, logic [1:0] st);
    stim_row_t r;
    r = item(m, lo, hi, v);
    r.typed = 1'b1;
    r.exp_res = res;
    r.exp_st = st;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, int data);
    stim_row_t r;
    r = item(MODE_WRITE, 0, 0, '0);
    r.kind = ROW_CFG;
    r.lo = IDX_W'(idx);
    r.val = DATA_W'(data);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return {$urandom, $urandom};
    if (r < 80) return 64'($signed($urandom_range(0, 200)) - 100);
    case (r % 4)
      0: return S64_MAX;
      1: return S64_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic stim_row_t rand_item();
    int r, n, lo, hi;
    logic [1:0] m;
    n = (cur_len > DEPTH_DEF) ? DEPTH_DEF : int'(cur_len);
    r = $urandom_range(0, 99);
    if (r < 35) m = MODE_WRITE;
    else if (r < 60) m = MODE_ADD;
    else if (r < 96) m = MODE_QUERY;
    else m = MODE_BAD;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 10) begin
      // noise: any indices at all
      lo = $urandom_range(0, DEPTH_DEF - 1);
      hi = $urandom_range(0, DEPTH_DEF - 1);
    end else begin
      lo = $urandom_range(0, n - 1);
      if (r < 20) hi = $urandom_range(lo, n - 1);
      else hi = lo + $urandom_range(0, 70);
      if (hi > n - 1) hi = n - 1;
    end
    return item(m, lo, hi, rand_value());
  endfunction

  // receiver: random stalls, with a long hold-off on request
  always @(posedge clk) begin : stall_gen
    int r;
    static int hold_left = 0;
    static int stall_left = 0;
    static int hold_seen = 0;
    r = $urandom_range(0, 99);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && r < 15) begin
      out_stall <= 1'b1;
      stall_left = (r < 2) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // check every result transfer against the oldest answer due
  always @(posedge clk) begin : result_check
    answer_t a;
    if (!rst && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result %h status %0d", $time, result, status);
        errors++;
      end else begin
        a = answers_due.pop_front();
        checked++;
        if (result !== a.res) begin
          $display("%0t: result expected %h actual %h", $time, a.res, result);
          errors++;
        end
        if (status !== a.st) begin
          $display("%0t: status expected %0d actual %0d", $time, a.st, status);
          errors++;
        end
      end
    end
  end

  initial begin : main
    int len_set[8];
    int items_per;
    for (int i = 0; i < DEPTH_DEF; i++) true_elem[i] = '0;
    cur_op = OP_SUM;
    cur_len = 11'd1024;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed rows: extremes, every mode, special cases
    dir_tab.push_back(typed(MODE_QUERY, 0, 1023, '0, '0, ST_OK));
    dir_tab.push_back(item(MODE_WRITE, 0, 0, S64_MAX));
    dir_tab.push_back(item(MODE_WRITE, 1023, 1023, S64_MIN));
    dir_tab.push_back(typed(MODE_QUERY, 0, 1023, '0, '1, ST_OK));
    dir_tab.push_back(item(MODE_ADD, 5, 900, 64'd1));
    dir_tab.push_back(item(MODE_QUERY, 0, 1023, '0));
    dir_tab.push_back(typed(MODE_QUERY, 10, 5, '0, '0, ST_RANGE));
    dir_tab.push_back(typed(MODE_BAD, 0, 1023, '1, '0, ST_RANGE));
    dir_tab.push_back(item(MODE_ADD, 0, 1023, '1));
    dir_tab.push_back(item(MODE_QUERY, 31, 32, '0));
    dir_tab.push_back(item(MODE_WRITE, 40, 0, 64'd7));
    dir_tab.push_back(item(MODE_QUERY, 33, 95, '0));
    dir_tab.push_back(cfg_row(REG_OP_SELECT, OP_MIN));
    dir_tab.push_back(typed(MODE_ADD, 0, 3, 64'd1, '0, ST_REFUSE));
    dir_tab.push_back(item(MODE_QUERY, 0, 1023, '0));
    dir_tab.push_back(cfg_row(REG_OP_SELECT, OP_MAX));
    dir_tab.push_back(item(MODE_QUERY, 0, 1023, '0));
    dir_tab.push_back(cfg_row(REG_OP_SELECT, 3));
    dir_tab.push_back(item(MODE_QUERY, 900, 1023, '0));
    dir_tab.push_back(cfg_row(REG_LENGTH, 0));
    dir_tab.push_back(typed(MODE_WRITE, 0, 0, 64'd5, '0, ST_RANGE));
    dir_tab.push_back(typed(MODE_QUERY, 0, 0, '0, '0, ST_RANGE));
    dir_tab.push_back(cfg_row(REG_LENGTH, 1));
    dir_tab.push_back(typed(MODE_WRITE, 1, 1, 64'd5, '0, ST_RANGE));
    dir_tab.push_back(item(MODE_QUERY, 0, 0, '0));
    dir_tab.push_back(cfg_row(REG_LENGTH, 2047));
    dir_tab.push_back(item(MODE_QUERY, 1000, 1023, '0));

    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) write_reg(dir_tab[k].lo[0], dir_tab[k].val[LEN_W-1:0]);
      else send_item(dir_tab[k]);
    end

    // random phases over several register settings
    len_set = '{1024, 2047, 1, 33, 1024, 0, 64, 1024};
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_OP_SELECT, LEN_W'((p % 5 == 4) ? 3 : p % 3));
      write_reg(REG_LENGTH, LEN_W'((p < 8) ? len_set[p] : $urandom_range(1, 2047)));
      items_per = (len_set[p % 8] == 0) ? 30 : 150;
      quiet = (p == 3);
      if (p == 2) hold_req++;
      for (int k = 0; k < items_per; k++) begin
        send_item(rand_item());
        sender_gap();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d items through 12 register settings, sum/min/max and bad ranges;",
             sent);
    $display("%0d results compared, %0d failures.", checked, errors);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/brqt_pkg.sv
hw/rtl/brqt_ram.sv
hw/rtl/brqt_datapath.sv
hw/rtl/brqt_ctrl.sv
hw/rtl/blocked_range_query_table.sv
hw/rtl/brqt_checker.sv
verif/tb.sv
